// ===== rtl/gte_pkg.sv =====
// ----------------------------------------------------------------------------
// gte_pkg
// Shared types, constants and the step tables for the gyro turn-rate
// estimator: operation codes, command word, controller states, coefficients.
// ----------------------------------------------------------------------------
package gte_pkg;

    localparam int SAMPLE_BITS_DEF       = 16;
    localparam int HISTORY_FRAC_BITS_DEF = 24;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 8'd1;

    localparam logic [15:0] ALPHA_RESET = 16'd7209;
    localparam logic [31:0] SCALE_RESET = 32'd328866;

    // round(2^40 / 7139.674717)
    localparam logic signed [32:0] INV_GAIN = 33'sd154000241;

    localparam logic [3:0] FILT_LAST = 4'd11;
    localparam logic [4:0] RATE_LAST = 5'd16;
    localparam logic [1:0] AXIS_LAST = 2'd2;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_FIR,
        OP_FB_LO,
        OP_FB_HI,
        OP_FB_RND,
        OP_UPD,
        OP_SAMP,
        OP_SQ,
        OP_SCL,
        OP_DEC,
        OP_TLO,
        OP_THI,
        OP_EST
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] axis;
        logic [1:0] tap;
        logic       first;
        logic       capture;
        logic       load_out;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILT,
        ST_RATE,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // feedback coefficients, q28, oldest output first
    function automatic logic signed [31:0] fb_coef(input logic [1:0] tap);
        logic signed [31:0] c;
        unique case (tap)
            2'd0: c = -32'sd127639863;
            2'd1: c = 32'sd608593792;
            2'd2: c = -32'sd1095226056;
            2'd3: c = 32'sd882106019;
            default: c = '0;
        endcase
        return c;
    endfunction

    // one axis of the lowpass: input term, eight feedback products, rounding, update, then the output sample
    function automatic cmd_t filt_cmd(input logic [3:0] phase, input logic [1:0] axis);
        cmd_t c;
        c          = '0;
        c.op       = OP_NOP;
        c.axis     = axis;
        c.tap      = 2'(phase - 4'd1 >> 1);
        c.first    = (phase == 4'd1);
        unique case (phase)
            4'd0:                          c.op = OP_FIR;
            4'd1, 4'd3, 4'd5, 4'd7:        c.op = OP_FB_LO;
            4'd2, 4'd4, 4'd6, 4'd8:        c.op = OP_FB_HI;
            4'd9:                          c.op = OP_FB_RND;
            4'd10:                         c.op = OP_UPD;
            4'd11:                         c.op = OP_SAMP;
            default:                       c.op = OP_NOP;
        endcase
        return c;
    endfunction

    // squares and smoothing; nops keep a product operand behind its write
    function automatic cmd_t rate_cmd(input logic [4:0] step);
        cmd_t c;
        c    = '0;
        c.op = OP_NOP;
        unique case (step)
            5'd0: begin
                c.op = OP_SQ; c.axis = 2'd0; c.first = 1'b1;
            end
            5'd1: begin
                c.op = OP_SQ; c.axis = 2'd1;
            end
            5'd3, 5'd11: c.op = OP_SCL;
            5'd5:  c.op = OP_DEC;
            5'd6, 5'd14: c.op = OP_TLO;
            5'd7, 5'd15: c.op = OP_THI;
            5'd8:  c.op = OP_EST;
            5'd9: begin
                c.op = OP_SQ; c.axis = 2'd2; c.first = 1'b1;
            end
            5'd13: begin
                c.op = OP_DEC; c.axis = 2'd1;
            end
            5'd16: begin
                c.op = OP_EST; c.axis = 2'd1;
            end
            default: c.op = OP_NOP;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/gte_ctrl.sv =====
// ----------------------------------------------------------------------------
// gte_ctrl
// Sequencer: walks the three filter axes and the rate update, issues one
// datapath command per cycle and runs the input and output handshakes.
// ----------------------------------------------------------------------------
module gte_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output gte_pkg::cmd_t cmd
);
    import gte_pkg::*;

    state_t     state_reg, state_next;
    logic [3:0] phase_reg, phase_next;
    logic [1:0] axis_reg, axis_next;
    logic [4:0] step_reg, step_next;
    logic       m_valid_reg, m_valid_next;
    logic       load_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= '0;
            axis_reg    <= '0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            axis_reg    <= axis_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        axis_next  = axis_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_FILT;
                    phase_next = '0;
                    axis_next  = '0;
                end
            end
            ST_FILT: begin
                if (phase_reg == FILT_LAST) begin
                    phase_next = '0;
                    if (axis_reg == AXIS_LAST) begin
                        state_next = ST_RATE;
                        step_next  = '0;
                    end else begin
                        axis_next = axis_reg + 2'd1;
                    end
                end else begin
                    phase_next = phase_reg + 4'd1;
                end
            end
            ST_RATE: begin
                if (step_reg == RATE_LAST) begin
                    state_next = ST_DRAIN;
                end else begin
                    step_next = step_reg + 5'd1;
                end
            end
            ST_DRAIN: state_next = ST_FINISH;
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        cmd.op   = OP_NOP;
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:   cmd.capture = s_valid;
            ST_FILT:   cmd = filt_cmd(phase_reg, axis_reg);
            ST_RATE:   cmd = rate_cmd(step_reg);
            ST_DRAIN:  cmd.op = OP_NOP;
            ST_FINISH: load_out = !m_valid_reg || m_ready;
            default:   cmd.op = OP_NOP;
        endcase
        cmd.load_out = load_out;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // no item is taken while reset is held
    assign s_ready = (state_reg == ST_IDLE) && aresetn;
    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/gte_datapath.sv =====
// ----------------------------------------------------------------------------
// gte_datapath
// Histories, one shared 33x33 multiplier with a registered product, the
// accumulator, the smoothed estimates, settings and the result registers.
// ----------------------------------------------------------------------------
module gte_datapath #(
    parameter int SAMPLE_BITS       = gte_pkg::SAMPLE_BITS_DEF,
    parameter int HISTORY_FRAC_BITS = gte_pkg::HISTORY_FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  gte_pkg::cmd_t                     cmd,
    input  logic signed [15:0]                s_raw_x,
    input  logic signed [15:0]                s_raw_y,
    input  logic signed [15:0]                s_raw_z,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gte_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gte_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic signed [15:0]                m_filtered_x,
    output logic signed [15:0]                m_filtered_y,
    output logic signed [15:0]                m_filtered_z,
    output logic [31:0]                       m_xy_rate_squared,
    output logic [31:0]                       m_z_rate_squared
);
    import gte_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int HFB    = HISTORY_FRAC_BITS;
    localparam int FW     = SB + 4;
    localparam int SH_IN  = 40 - HFB;
    localparam logic signed [65:0] RND_IN  = 66'sd1 <<< (39 - HFB);
    localparam logic signed [48:0] RND_OUT = 49'sd1 <<< (HFB - 1);
    localparam logic signed [54:0] HMAX = 55'sd140737488355327;
    localparam logic signed [54:0] HMIN = -55'sd140737488355328;
    localparam logic signed [48:0] SMAX = 49'sd32767;
    localparam logic signed [48:0] SMIN = -49'sd32768;

    logic signed [SB-1:0] samp_reg [3];
    logic signed [SB-1:0] hin_reg  [3][4];
    logic signed [47:0]   hout_reg [3][4];
    logic signed [15:0]   f_reg    [3];
    logic [31:0]          est_reg  [2];
    logic [15:0]          alpha_reg;
    logic [31:0]          scale_reg;

    cmd_t                 cmd_d_reg;
    logic signed [65:0]   prod_reg;
    logic signed [81:0]   acc_reg;
    logic signed [47:0]   term_reg;
    logic signed [53:0]   fb_reg;
    logic [31:0]          sq_reg;
    logic [47:0]          t_reg;

    logic signed [SB-1:0] ry, rz;
    logic signed [FW-1:0] fir;
    logic signed [47:0]   y_sel;
    logic signed [31:0]   coef;
    logic signed [32:0]   mul_a, mul_b;
    logic signed [54:0]   ysum;
    logic signed [47:0]   y_new;
    logic signed [48:0]   vr;
    logic signed [15:0]   f_new;
    logic [57:0]          est_r;
    logic [31:0]          est_new;

    assign cfg_ready = aresetn;
    assign ry = s_raw_y[SB-1:0];
    assign rz = s_raw_z[SB-1:0];

    // binomial input taps of the current axis, newest sample included
    always_comb begin
        fir = FW'(samp_reg[cmd.axis]) + FW'(hin_reg[cmd.axis][0])
            + ((FW'(hin_reg[cmd.axis][1]) + FW'(hin_reg[cmd.axis][3])) <<< 2)
            + (FW'(hin_reg[cmd.axis][2]) <<< 2) + (FW'(hin_reg[cmd.axis][2]) <<< 1);
    end

    assign y_sel = hout_reg[cmd.axis][cmd.tap];
    assign coef  = fb_coef(cmd.tap);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_FIR: begin
                mul_a = 33'(fir);
                mul_b = INV_GAIN;
            end
            OP_FB_LO: begin
                mul_a = 33'(coef);
                mul_b = {9'd0, y_sel[23:0]};
            end
            OP_FB_HI: begin
                mul_a = 33'(coef);
                mul_b = 33'($signed(y_sel[47:24]));
            end
            OP_SQ: begin
                mul_a = 33'(f_reg[cmd.axis]);
                mul_b = 33'(f_reg[cmd.axis]);
            end
            OP_SCL: begin
                mul_a = {1'b0, sq_reg};
                mul_b = {1'b0, scale_reg};
            end
            OP_DEC: begin
                mul_a = {1'b0, est_reg[cmd.axis[0]]};
                mul_b = {16'd0, 17'h10000 - {1'b0, alpha_reg}};
            end
            OP_TLO: begin
                mul_a = {17'd0, alpha_reg};
                mul_b = {9'd0, t_reg[23:0]};
            end
            OP_THI: begin
                mul_a = {17'd0, alpha_reg};
                mul_b = {9'd0, t_reg[47:24]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // new output of the axis, saturated to the history width
    always_comb begin
        ysum = 55'(term_reg) + 55'(fb_reg);
        if (ysum > HMAX) begin
            y_new = HMAX[47:0];
        end else if (ysum < HMIN) begin
            y_new = HMIN[47:0];
        end else begin
            y_new = ysum[47:0];
        end
    end

    // round the newest output to an integer sample
    always_comb begin
        vr = (49'(hout_reg[cmd_d_reg.axis][3]) + RND_OUT) >>> HFB;
        if (vr > SMAX) begin
            f_new = 16'sh7FFF;
        end else if (vr < SMIN) begin
            f_new = -16'sh8000;
        end else begin
            f_new = vr[15:0];
        end
    end

    always_comb begin
        est_r = 58'((acc_reg + 82'sd8388608) >>> 24);
        if (est_r[57:32] != '0) begin
            est_new = 32'hFFFF_FFFF;
        end else begin
            est_new = est_r[31:0];
        end
    end

    // state that reset clears or sets to its defaults
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < 3; a++) begin
                for (int i = 0; i < 4; i++) begin
                    hin_reg[a][i]  <= '0;
                    hout_reg[a][i] <= '0;
                end
            end
            est_reg[0] <= '0;
            est_reg[1] <= '0;
            alpha_reg  <= ALPHA_RESET;
            scale_reg  <= SCALE_RESET;
            cmd_d_reg  <= '0;
        end else begin
            cmd_d_reg <= cmd;
            if (cfg_valid) begin
                if (cfg_index == CFG_ALPHA) begin
                    alpha_reg <= cfg_data[15:0];
                end else if (cfg_index == CFG_SCALE) begin
                    scale_reg <= cfg_data[31:0];
                end
            end
            if (cmd_d_reg.op == OP_UPD) begin
                for (int i = 0; i < 3; i++) begin
                    hin_reg[cmd_d_reg.axis][i]  <= hin_reg[cmd_d_reg.axis][i+1];
                    hout_reg[cmd_d_reg.axis][i] <= hout_reg[cmd_d_reg.axis][i+1];
                end
                hin_reg[cmd_d_reg.axis][3]  <= samp_reg[cmd_d_reg.axis];
                hout_reg[cmd_d_reg.axis][3] <= y_new;
            end
            if (cmd_d_reg.op == OP_EST) begin
                est_reg[cmd_d_reg.axis[0]] <= est_new;
            end
        end
    end

    // working registers: product stage, then write-back of the delayed command
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (cmd.capture) begin
            samp_reg[0] <= -ry;
            samp_reg[1] <= -rz;
            samp_reg[2] <= s_raw_x[SB-1:0];
        end
        unique case (cmd_d_reg.op)
            OP_FIR:    term_reg <= 48'((prod_reg + RND_IN) >>> SH_IN);
            OP_FB_LO:  acc_reg  <= (cmd_d_reg.first ? 82'sd0 : acc_reg) + 82'(prod_reg);
            OP_FB_HI:  acc_reg  <= acc_reg + (82'(prod_reg) <<< 24);
            OP_FB_RND: fb_reg   <= 54'((acc_reg + 82'sd134217728) >>> 28);
            OP_SAMP:   f_reg[cmd_d_reg.axis] <= f_new;
            OP_SQ:     sq_reg   <= (cmd_d_reg.first ? 32'd0 : sq_reg) + prod_reg[31:0];
            OP_SCL:    t_reg    <= prod_reg[63:16];
            OP_DEC:    acc_reg  <= 82'(prod_reg) <<< 8;
            OP_TLO:    acc_reg  <= acc_reg + 82'(prod_reg);
            OP_THI:    acc_reg  <= acc_reg + (82'(prod_reg) <<< 24);
            default:   ;
        endcase
        if (cmd.load_out) begin
            m_filtered_x      <= f_reg[0];
            m_filtered_y      <= f_reg[1];
            m_filtered_z      <= f_reg[2];
            m_xy_rate_squared <= est_reg[0];
            m_z_rate_squared  <= est_reg[1];
        end
    end

endmodule

// ===== rtl/gyro_turn_rate_estimator_unit.sv =====
// ----------------------------------------------------------------------------
// gyro_turn_rate_estimator_unit
// Remaps a three-axis gyro sample, lowpasses each axis with a fourth-order
// Bessel filter and smooths the squared xy and z turn rates.
// ----------------------------------------------------------------------------
// usage:
//   s_* channel takes one raw sample item (s_raw_x/y/z) per valid/ready
//   handshake; m_* channel returns one result item per sample: three
//   filtered axes and the two smoothed squared rates.
//   cfg_* channel writes smoothing_alpha (index 0) and rate_scale (index 1);
//   other indexes are dropped. cfg_ready is high out of reset; write only
//   while the block is idle.
//   the sequencer issues 53 operations around one shared 33x33 multiplier
//   (12 per filter axis, 17 for the squares and smoothing), plus a drain
//   and a hand-off step; one sample is in work at a time, so a new item
//   is taken only once the last result is loaded into the output register.
//   a finished result sits in the output register; s_ready comes back as
//   soon as it is loaded, so a stalled receiver blocks only the hand-off
//   of the next result.
//   reset (aresetn low, synchronous) clears all filter histories and both
//   estimates and restores the register defaults.
// ----------------------------------------------------------------------------
module gyro_turn_rate_estimator_unit #(
    parameter int SAMPLE_BITS       = gte_pkg::SAMPLE_BITS_DEF,
    parameter int HISTORY_FRAC_BITS = gte_pkg::HISTORY_FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [15:0]             s_raw_x,
    input  logic signed [15:0]             s_raw_y,
    input  logic signed [15:0]             s_raw_z,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [15:0]             m_filtered_x,
    output logic signed [15:0]             m_filtered_y,
    output logic signed [15:0]             m_filtered_z,
    output logic [31:0]                    m_xy_rate_squared,
    output logic [31:0]                    m_z_rate_squared,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gte_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gte_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gte_pkg::*;

    cmd_t cmd;

    gte_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    gte_datapath #(
        .SAMPLE_BITS       (SAMPLE_BITS),
        .HISTORY_FRAC_BITS (HISTORY_FRAC_BITS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .s_raw_x           (s_raw_x),
        .s_raw_y           (s_raw_y),
        .s_raw_z           (s_raw_z),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .m_filtered_x      (m_filtered_x),
        .m_filtered_y      (m_filtered_y),
        .m_filtered_z      (m_filtered_z),
        .m_xy_rate_squared (m_xy_rate_squared),
        .m_z_rate_squared  (m_z_rate_squared)
    );

endmodule

// ===== test/tb_gyro_turn_rate_estimator_unit.sv =====
// ----------------------------------------------------------------------------
// tb_gyro_turn_rate_estimator_unit
// Self-checking bench for the gyro turn-rate estimator. A bit-exact predictor
// of the axis remap, the three Bessel lowpass filters and the two smoothed
// squared rates runs beside the block. Every output item is compared with
// the oldest predicted one. Both channels idle at random, and the register
// settings change between phases.
// ----------------------------------------------------------------------------
module tb_gyro_turn_rate_estimator_unit;
    import gte_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 70;

    typedef struct {
        logic signed [15:0] fx;
        logic signed [15:0] fy;
        logic signed [15:0] fz;
        logic [31:0]        xy_sq;
        logic [31:0]        z_sq;
    } rate_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_raw_x = '0;
    logic signed [15:0] s_raw_y = '0;
    logic signed [15:0] s_raw_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [15:0] m_filtered_x;
    logic signed [15:0] m_filtered_y;
    logic signed [15:0] m_filtered_z;
    logic [31:0] m_xy_rate_squared;
    logic [31:0] m_z_rate_squared;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    gyro_turn_rate_estimator_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_raw_x(s_raw_x), .s_raw_y(s_raw_y), .s_raw_z(s_raw_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_filtered_x(m_filtered_x), .m_filtered_y(m_filtered_y),
        .m_filtered_z(m_filtered_z),
        .m_xy_rate_squared(m_xy_rate_squared), .m_z_rate_squared(m_z_rate_squared),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 aclk = ~aclk;

    // predictor state
    const longint FB_Q28[4] = '{-64'sd127639863, 64'sd608593792,
                                -64'sd1095226056, 64'sd882106019};
    const longint HIST_MAX = 64'sh7FFF_FFFF_FFFF;
    const longint HIST_MIN = -64'sh8000_0000_0000;
    longint sample_hist[3][4];
    longint filter_hist[3][4];
    logic [31:0] xy_estimate = '0;
    logic [31:0] z_estimate = '0;
    logic [15:0] alpha_reg = ALPHA_RESET;
    logic [31:0] scale_reg = SCALE_RESET;

    rate_result_t expected_rates[$];
    int error_count = 0;
    int idle_cycles = 0;

    // sender pacing and receiver control
    int burst_left = 0;
    bit sender_gaps = 1'b1;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_length = 0;
    int hold_left = 0;
    int ready_mode = 0;

    function automatic longint lowpass_axis(int a, longint s);
        longint fir, in_term, hi, lo, fb, y;
        fir = sample_hist[a][0] + s + 4 * (sample_hist[a][1] + sample_hist[a][3])
              + 6 * sample_hist[a][2];
        in_term = (fir * longint'(INV_GAIN) + (64'sd1 <<< 15)) >>> 16;
        hi = 0;
        lo = 0;
        for (int i = 0; i < 4; i++) begin
            lo += FB_Q28[i] * (filter_hist[a][i] & 64'sh00FF_FFFF);
            hi += FB_Q28[i] * (filter_hist[a][i] >>> 24);
        end
        lo += 64'sd1 <<< 27;
        fb = (hi + (lo >>> 24)) >>> 4;
        y = in_term + fb;
        if (y > HIST_MAX) y = HIST_MAX;
        if (y < HIST_MIN) y = HIST_MIN;
        for (int i = 0; i < 3; i++) begin
            sample_hist[a][i] = sample_hist[a][i + 1];
            filter_hist[a][i] = filter_hist[a][i + 1];
        end
        sample_hist[a][3] = s;
        filter_hist[a][3] = y;
        return y;
    endfunction

    function automatic logic signed [15:0] round_to_rate(longint y);
        longint r;
        r = (y + (64'sd1 <<< 23)) >>> 24;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return 16'(r);
    endfunction

    function automatic logic [31:0] smooth_rate(logic [31:0] prev, longint unsigned sq);
        longint unsigned t, acc, p, a;
        p = prev;
        a = alpha_reg;
        t = (sq * longint'(scale_reg)) >> 16;
        acc = (p << 8) * (64'd65536 - a) + a * t + (64'd1 << 23);
        acc = acc >> 24;
        if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
        return acc[31:0];
    endfunction

    function automatic rate_result_t predict_rates(logic signed [15:0] rx,
                                                   logic signed [15:0] ry,
                                                   logic signed [15:0] rz);
        rate_result_t r;
        logic signed [15:0] ax, ay;
        longint sx, sy, sz;
        // negation wraps, so the most negative sample maps to itself
        ax = -ry;
        ay = -rz;
        r.fx = round_to_rate(lowpass_axis(0, longint'(ax)));
        r.fy = round_to_rate(lowpass_axis(1, longint'(ay)));
        r.fz = round_to_rate(lowpass_axis(2, longint'(rx)));
        sx = r.fx;
        sy = r.fy;
        sz = r.fz;
        xy_estimate = smooth_rate(xy_estimate, longint'(sx * sx + sy * sy));
        z_estimate = smooth_rate(z_estimate, longint'(sz * sz));
        r.xy_sq = xy_estimate;
        r.z_sq = z_estimate;
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch: %s", what);
        error_count++;
    endtask

    // result checking and watchdog, sampled away from the driving edge
    always @(negedge aclk) begin
        rate_result_t e;
        if (m_valid && m_ready) begin
            if (expected_rates.size() == 0) begin
                report_mismatch("result item with nothing expected");
            end else begin
                e = expected_rates.pop_front();
                if (m_filtered_x !== e.fx)
                    report_mismatch($sformatf("filtered_x %0d exp %0d", m_filtered_x, e.fx));
                if (m_filtered_y !== e.fy)
                    report_mismatch($sformatf("filtered_y %0d exp %0d", m_filtered_y, e.fy));
                if (m_filtered_z !== e.fz)
                    report_mismatch($sformatf("filtered_z %0d exp %0d", m_filtered_z, e.fz));
                if (m_xy_rate_squared !== e.xy_sq)
                    report_mismatch($sformatf("xy_rate_squared %0d exp %0d",
                                              m_xy_rate_squared, e.xy_sq));
                if (m_z_rate_squared !== e.z_sq)
                    report_mismatch($sformatf("z_rate_squared %0d exp %0d",
                                              m_z_rate_squared, e.z_sq));
            end
        end
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: random stall pattern, with an occasional long hold-off
    always @(posedge aclk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left = hold_length;
        end
        if ($urandom_range(0, 199) == 0)
            ready_mode = $urandom_range(0, 2);
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (ready_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ($urandom_range(0, 1) != 0);
            endcase
        end
    end

    // all tasks start and end just after a rising edge
    task automatic send_sample(logic signed [15:0] rx, logic signed [15:0] ry,
                               logic signed [15:0] rz);
        bit took;
        if (sender_gaps && burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(1, 20);
        end
        if (burst_left > 0) burst_left--;
        s_valid <= 1'b1;
        s_raw_x <= rx;
        s_raw_y <= ry;
        s_raw_z <= rz;
        do begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end while (!took);
        expected_rates.push_back(predict_rates(rx, ry, rz));
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        bit took;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do begin
            @(negedge aclk);
            took = cfg_ready;
            @(posedge aclk);
        end while (!took);
        if (idx == CFG_ALPHA) alpha_reg = value[15:0];
        else if (idx == CFG_SCALE) scale_reg = value;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        burst_left = 0;
        while (expected_rates.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic signed [15:0] any_sample();
        return 16'($urandom);
    endfunction

    // extremes, wrapped negation and a full-scale square wave into saturation
    task automatic test_directed_extremes();
        send_sample(16'sh0000, 16'sh0000, 16'sh0000);
        send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_sample(-16'sh8000, -16'sh8000, -16'sh8000);
        send_sample(16'sh7FFF, -16'sh8000, 16'sh0001);
        send_sample(-16'sh8000, 16'sh7FFF, -16'sh0001);
        for (int i = 0; i < 16; i++) begin
            if ((i / 8) % 2 == 0)
                send_sample(16'sh7FFF, -16'sh8000, -16'sh8000);
            else
                send_sample(-16'sh8000, 16'sh7FFF, 16'sh7FFF);
        end
        wait_drained();
    endtask

    task automatic test_register_extremes();
        logic [15:0] alphas[4] = '{16'd0, 16'hFFFF, 16'd1, 16'h8000};
        logic [31:0] scales[4] = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'h8000_0000};
        for (int k = 0; k < 4; k++) begin
            write_register(CFG_ALPHA, {16'($urandom), alphas[k]});
            write_register(CFG_SCALE, scales[k]);
            // indexes past the register list are dropped
            write_register(CFG_IDX_W'($urandom_range(2, 255)), $urandom);
            for (int i = 0; i < 15; i++) begin
                if (i < 8) send_sample(16'sh7FFF, -16'sh8000, 16'sh7FFF);
                else send_sample(any_sample(), any_sample(), any_sample());
            end
            wait_drained();
        end
        write_register(CFG_ALPHA, ALPHA_RESET);
        write_register(CFG_SCALE, SCALE_RESET);
    endtask

    // segments of held steps, ramps and small noise, mixed with full-range noise
    task automatic test_random_motion(int count);
        logic signed [15:0] bx, by, bz, dx, dy, dz;
        int kind, len, sent;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(0, 3);
            len = $urandom_range(8, 40);
            bx = any_sample();
            by = any_sample();
            bz = any_sample();
            dx = 16'($urandom_range(0, 600)) - 16'sd300;
            dy = 16'($urandom_range(0, 600)) - 16'sd300;
            dz = 16'($urandom_range(0, 600)) - 16'sd300;
            sender_gaps = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < len && sent < count; i++) begin
                case (kind)
                    0: send_sample(bx, by, bz);
                    1: send_sample(bx + dx * 16'(i), by + dy * 16'(i), bz + dz * 16'(i));
                    2: send_sample(bx + 16'($urandom_range(0, 63)) - 16'sd32,
                                   by + 16'($urandom_range(0, 63)) - 16'sd32,
                                   bz + 16'($urandom_range(0, 63)) - 16'sd32);
                    default: send_sample(any_sample(), any_sample(), any_sample());
                endcase
                sent++;
            end
        end
        sender_gaps = 1'b1;
        wait_drained();
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_output_backpressure();
        hold_length = 500;
        hold_requests++;
        sender_gaps = 1'b0;
        for (int i = 0; i < 12; i++) send_sample(any_sample(), any_sample(), any_sample());
        sender_gaps = 1'b1;
        wait_drained();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_extremes();
        test_register_extremes();
        test_random_motion(250);
        test_output_backpressure();
        write_register(CFG_ALPHA, $urandom);
        write_register(CFG_SCALE, $urandom_range(1000, 5000000));
        test_random_motion(250);
        write_register(CFG_ALPHA, $urandom_range(1000, 20000));
        write_register(CFG_SCALE, $urandom);
        test_random_motion(300);
        wait_drained();
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== gyro_turn_rate_estimator_unit.f =====
rtl/gte_pkg.sv
rtl/gte_ctrl.sv
rtl/gte_datapath.sv
rtl/gyro_turn_rate_estimator_unit.sv
test/tb_gyro_turn_rate_estimator_unit.sv
